// ===== sv/x86ex_pkg.sv =====
// shared types, constants and helpers for the x86 register alu execute core
// no dependencies; imported by x86_16_register_alu_execute_core
package x86ex_pkg;

    localparam int REG_W       = 16;
    localparam int FLAG_W      = 12;
    localparam int NUM_ENTRIES = 12;
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);
    localparam int SEL_W       = 4;
    localparam int ACT_W       = 3;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    localparam logic [ACT_W-1:0] ACT_MOV = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CMP = 3'd3;

    localparam logic [SEL_W-1:0] SEL_SEG_BASE = 4'd8;
    localparam logic [SEL_W-1:0] SEL_LIMIT    = 4'd12;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNSUP = 1'b1;

    // flag bit positions
    localparam int FL_CF = 0;
    localparam int FL_PF = 2;
    localparam int FL_AF = 4;
    localparam int FL_ZF = 6;
    localparam int FL_SF = 7;
    localparam int FL_OF = 11;

    localparam logic [REG_W-1:0] MASK_HI   = 16'hFF00;
    localparam logic [REG_W-1:0] MASK_LO   = 16'h00FF;
    localparam logic [REG_W-1:0] MASK_WORD = 16'hFFFF;
    localparam logic [REG_W-1:0] SIGN_WORD = 16'h8000;

    // listed from the top bit down, so action sits in the lowest bits of tdata
    typedef struct packed {
        logic [REG_W-1:0]  imm_value;
        logic [SEL_W-1:0]  src_sel;
        logic              src_is_imm;
        logic [SEL_W-1:0]  dest_sel;
        logic              wide;
        logic [ACT_W-1:0]  action;
    } t_item;

    // physical word holding a selector: segment regs at 8..11, byte regs share words 0..3
    function automatic logic [ADDR_W-1:0] f_phys_addr(input logic [SEL_W-1:0] sel,
                                                      input logic wide);
        logic [ADDR_W-1:0] addr;
        if (sel >= SEL_LIMIT) begin
            addr = '0;
        end else if (sel >= SEL_SEG_BASE || wide) begin
            addr = sel[ADDR_W-1:0];
        end else begin
            addr = {2'b00, sel[1:0]};
        end
        return addr;
    endfunction

    // operand value of a selector taken from its physical word
    function automatic logic [REG_W-1:0] f_read_op(input logic [SEL_W-1:0] sel,
                                                   input logic wide,
                                                   input logic [REG_W-1:0] word);
        logic [REG_W-1:0] v;
        if (sel >= SEL_SEG_BASE || wide) begin
            v = word;
        end else if (sel[2]) begin
            v = (word & MASK_HI) >> 8;
        end else begin
            v = word & MASK_LO;
        end
        return v;
    endfunction

    // selector that names nothing this operation can use
    function automatic logic f_bad_sel(input logic [SEL_W-1:0] sel,
                                       input logic wide,
                                       input logic [ACT_W-1:0] action);
        return (sel >= SEL_LIMIT) ||
               (sel >= SEL_SEG_BASE && (!wide || action != ACT_MOV));
    endfunction

endpackage

// ===== sv/x86ex_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies; used for the register file copies
module x86ex_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/x86_16_register_alu_execute_core.sv =====
// execute core for register-form mov, add, sub and cmp with its own register file
// depends on x86ex_pkg and x86ex_ram
//
// usage:
//   slave channel (i_s_*) takes one decoded instruction per item; master channel
//   (o_m_*) returns one result item per instruction, in order.
//   the eight general and four segment registers live in a 12-word ram, held as
//   two copies so the destination and source words are read in the same cycle.
//   an item is accepted, its words are read at that edge, and in the next cycle
//   the alu computes the result; when the output register is free or being
//   drained, the merged word is written back and the output register loaded,
//   which offers the result on the master channel.
//   throughput is one item per cycle unless stalled; a write still landing in
//   the ram is forwarded from a bypass register to the following item.
//   reset clears the per-word valid bits (an unwritten word reads as zero),
//   the flags, the bypass and both pipeline valids; no clearing pass is needed.
//   when the receiver stalls, the finished item waits in the output register,
//   one more item waits in the execute stage, and o_s_tready drops.
module x86_16_register_alu_execute_core
    import x86ex_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // action[2:0], wide[3], dest_sel[7:4], src_is_imm[8], src_sel[12:9],
    // imm_value[28:13], zero[31:29]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // result_value[15:0], flag_word[27:16], status[28], zero[31:29]
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_item             in_item;
    t_item             r_s1_item;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_daddr;
    logic [ADDR_W-1:0] r_s1_saddr;
    logic              adv;
    logic              in_ready;

    logic [ADDR_W-1:0] rd_daddr;
    logic [ADDR_W-1:0] rd_saddr;
    logic [REG_W-1:0]  ram_dword;
    logic [REG_W-1:0]  ram_sword;

    logic [NUM_ENTRIES-1:0] r_ent_valid;
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [REG_W-1:0]  r_fwd_data;

    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] n_flags;

    logic              r_out_valid;
    logic [REG_W-1:0]  r_out_result;
    logic [FLAG_W-1:0] r_out_flags;
    logic              r_out_status;

    logic [REG_W-1:0]  dword;
    logic [REG_W-1:0]  sword;
    logic [REG_W-1:0]  mask;
    logic [REG_W-1:0]  sign;
    logic [REG_W-1:0]  op_a;
    logic [REG_W-1:0]  op_b;
    logic [REG_W:0]    sum;
    logic [REG_W:0]    diff;
    logic [REG_W-1:0]  res;
    logic              cf;
    logic              of;
    logic              bad;
    logic [REG_W-1:0]  wr_word;
    logic              wr_en;

    assign in_item = t_item'(i_s_tdata[$bits(t_item)-1:0]);

    assign adv        = !r_out_valid || i_m_tready;
    assign in_ready   = !r_s1_valid || adv;
    assign o_s_tready = in_ready;

    // re-read the held item's words while stalled, so late writes are seen
    always_comb begin
        if (in_ready) begin
            rd_daddr = f_phys_addr(in_item.dest_sel, in_item.wide);
            rd_saddr = f_phys_addr(in_item.src_sel, in_item.wide);
        end else begin
            rd_daddr = r_s1_daddr;
            rd_saddr = r_s1_saddr;
        end
    end

    x86ex_ram #(.WIDTH(REG_W), .DEPTH(NUM_ENTRIES)) u_ram_dest (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_daddr),
        .i_wr_data (wr_word),
        .i_rd_addr (rd_daddr),
        .o_rd_data (ram_dword)
    );

    x86ex_ram #(.WIDTH(REG_W), .DEPTH(NUM_ENTRIES)) u_ram_src (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_daddr),
        .i_wr_data (wr_word),
        .i_rd_addr (rd_saddr),
        .o_rd_data (ram_sword)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_s1_item  <= in_item;
            r_s1_daddr <= rd_daddr;
            r_s1_saddr <= rd_saddr;
        end
    end

    // stage 1: word selection with bypass and reset-value substitution
    always_comb begin
        if (r_fwd_valid && r_fwd_addr == r_s1_daddr) begin
            dword = r_fwd_data;
        end else if (r_ent_valid[r_s1_daddr]) begin
            dword = ram_dword;
        end else begin
            dword = '0;
        end
        if (r_fwd_valid && r_fwd_addr == r_s1_saddr) begin
            sword = r_fwd_data;
        end else if (r_ent_valid[r_s1_saddr]) begin
            sword = ram_sword;
        end else begin
            sword = '0;
        end
    end

    always_comb begin
        mask = r_s1_item.wide ? MASK_WORD : MASK_LO;
        sign = r_s1_item.wide ? SIGN_WORD : (SIGN_WORD >> 8);
        bad  = (r_s1_item.action > ACT_CMP) ||
               f_bad_sel(r_s1_item.dest_sel, r_s1_item.wide, r_s1_item.action) ||
               (!r_s1_item.src_is_imm &&
                f_bad_sel(r_s1_item.src_sel, r_s1_item.wide, r_s1_item.action));

        op_a = f_read_op(r_s1_item.dest_sel, r_s1_item.wide, dword) & mask;
        op_b = r_s1_item.src_is_imm ? (r_s1_item.imm_value & mask)
                                    : (f_read_op(r_s1_item.src_sel, r_s1_item.wide,
                                                 sword) & mask);
        sum  = {1'b0, op_a} + {1'b0, op_b};
        diff = {1'b0, op_a} - {1'b0, op_b};

        n_flags = r_flags;
        res     = '0;
        cf      = 1'b0;
        of      = 1'b0;
        case (r_s1_item.action)
            ACT_MOV: begin
                res = op_b;
            end
            ACT_ADD: begin
                res = sum[REG_W-1:0] & mask;
                cf  = r_s1_item.wide ? sum[REG_W] : sum[8];
                of  = |((op_a ^ res) & (op_b ^ res) & sign);
            end
            ACT_SUB, ACT_CMP: begin
                res = diff[REG_W-1:0] & mask;
                cf  = diff[REG_W];
                of  = |((op_a ^ op_b) & (op_a ^ res) & sign);
            end
            default: begin
                res = '0;
            end
        endcase

        if (r_s1_item.action != ACT_MOV) begin
            n_flags[FL_CF] = cf;
            n_flags[FL_PF] = ~^res[7:0];
            n_flags[FL_AF] = op_a[4] ^ op_b[4] ^ res[4];
            n_flags[FL_ZF] = (res == '0);
            n_flags[FL_SF] = |(res & sign);
            n_flags[FL_OF] = of;
        end

        // merge a byte result into its word
        if (r_s1_item.dest_sel >= SEL_SEG_BASE || r_s1_item.wide) begin
            wr_word = res;
        end else if (r_s1_item.dest_sel[2]) begin
            wr_word = {res[7:0], dword[7:0]};
        end else begin
            wr_word = {dword[15:8], res[7:0]};
        end

        wr_en = adv && r_s1_valid && !bad && (r_s1_item.action != ACT_CMP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_fwd_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (wr_en) begin
                r_ent_valid[r_s1_daddr] <= 1'b1;
                r_fwd_valid             <= 1'b1;
            end
            if (adv && r_s1_valid && !bad) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_s1_daddr;
            r_fwd_data <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_result <= bad ? '0 : res;
            r_out_flags  <= bad ? r_flags : n_flags;
            r_out_status <= bad ? STATUS_UNSUP : STATUS_OK;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - REG_W - FLAG_W - 1){1'b0}},
                         r_out_status, r_out_flags, r_out_result};

    // an item held in the execute stage is never dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("execute stage item lost while stalled");

    // cmp and rejected items never write the register file
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (bad || r_s1_item.action == ACT_CMP)) |-> !wr_en)
        else $error("register write from cmp or unsupported item");

    // a written word is marked valid and sits in the bypass next cycle
    a_wr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_ent_valid[r_fwd_addr] && r_fwd_addr == $past(r_s1_daddr)))
        else $error("written word not tracked");

    // mov leaves the flags alone
    a_mov_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && r_s1_item.action == ACT_MOV) |=> $stable(r_flags))
        else $error("flags changed by mov");

    // results leave only from a loaded output register
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> $past(r_s1_valid))
        else $error("output item without a source");

endmodule
